// ===== rtl/core/wsc_pkg.sv =====
// Shared constants, codes and types of the wavetable sound channels.
package wsc_pkg;

  localparam int unsigned AccW      = 32;
  localparam int unsigned CcW       = 8;
  localparam int unsigned OffW      = 11;
  localparam int unsigned DataW     = 8;
  localparam int unsigned SmpW      = 6;
  localparam int unsigned SumW      = 13;
  localparam int unsigned PosW      = 5;
  localparam int unsigned IvlW      = 6;
  localparam int unsigned TblW      = 3;
  localparam int unsigned ChW       = 3;
  localparam int unsigned NumCh     = 6;
  localparam int unsigned NumVoices = 5;
  localparam int unsigned WaveDepth = 160;
  localparam int unsigned WaveAw    = 8;
  localparam int unsigned PeriodW   = 14;

  localparam logic [AccW-1:0] OFF_TICK_CYCLES = 32'd77;
  localparam logic [AccW-1:0] MIX_PERIOD      = 32'd453;
  localparam logic [OffW-1:0] WAVE_END        = 11'h280;
  localparam logic [OffW-1:0] MOD_END         = 11'h400;
  localparam logic [OffW-1:0] SHUTOFF_PORT    = 11'h580;
  localparam logic [11:0]     FREQ_BASE       = 12'd2048;
  localparam logic [ChW-1:0]  LAST_CH         = 3'd5;
  localparam logic [ChW-1:0]  LAST_VOICE      = 3'd4;
  localparam logic [TblW-1:0] MAX_TBL         = 3'd4;

  typedef enum logic [2:0] {
    REG_CTRL = 3'd0,
    REG_VOL  = 3'd1,
    REG_FLO  = 3'd2,
    REG_FHI  = 3'd3,
    REG_TBL  = 3'd6
  } creg_e;

  typedef enum logic {
    ALU_ADD_SAT = 1'b0,
    ALU_SUB_GE  = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic [AccW-1:0] res;
    logic            ge;
  } alu_out_t;

endpackage

// ===== rtl/core/wsc_alu.sv =====
// Shared 32-bit saturating add and compare-subtract unit.
module wsc_alu
  import wsc_pkg::*;
(
  input  alu_op_e         op_i,
  input  logic [AccW-1:0] a_i,
  input  logic [AccW-1:0] b_i,
  output alu_out_t        out_o
);

  logic            sub;
  logic [AccW:0]   b_ext;
  logic [AccW:0]   sum;

  assign sub   = (op_i == ALU_SUB_GE);
  assign b_ext = sub ? {1'b0, ~b_i} : {1'b0, b_i};
  assign sum   = {1'b0, a_i} + b_ext + {{AccW{1'b0}}, sub};

  always_comb begin
    out_o.ge = sum[AccW];
    if (sub) begin
      out_o.res = sum[AccW] ? sum[AccW-1:0] : a_i;
    end else begin
      out_o.res = sum[AccW] ? {AccW{1'b1}} : sum[AccW-1:0];
    end
  end

endmodule

// ===== rtl/core/wsc_wave_ram.sv =====
// Wave sample memory with per-entry valid bits; unwritten entries read as zero.
module wsc_wave_ram
  import wsc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [WaveAw-1:0] waddr_i,
  input  logic [SmpW-1:0]   wdata_i,
  input  logic [WaveAw-1:0] raddr_i,
  output logic [SmpW-1:0]   rdata_o
);

  logic [SmpW-1:0]      mem [WaveDepth];
  logic [WaveDepth-1:0] valid_q;
  logic [SmpW-1:0]      rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= valid_q[raddr_i] ? mem[raddr_i] : '0;
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/wavetable_sound_channels.sv =====
// Five-voice wavetable sound unit: a register write is taken while the block
// is idle and the block stays ready. A tick, once accepted, steps the single
// shared 32-bit saturating add and compare-subtract unit in turn through each
// channel's auto-off counter, each voice's period counter and the sample
// counter (an add and a compare-subtract per active counter, an add alone per
// idle one); on a sample tick it then reads wave memory and mixes each voice
// and hands over the result, and that last step is held for as long as the
// previous sample still waits unaccepted in the output register. The input is
// not ready during a tick; a finished sample waits in the output register
// while the next item is taken.
module wavetable_sound_channels
  import wsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // reg_offset[10:0], write_data[18:11], cycle_count[26:19]
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // left_sum[12:0], right_sum[25:13]
);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_OFF_ADD = 10'b0000000010,
    ST_OFF_SUB = 10'b0000000100,
    ST_V_ADD   = 10'b0000001000,
    ST_V_SUB   = 10'b0000010000,
    ST_S_ADD   = 10'b0000100000,
    ST_S_SUB   = 10'b0001000000,
    ST_MIX_RD  = 10'b0010000000,
    ST_MIX_ACC = 10'b0100000000,
    ST_EMIT    = 10'b1000000000
  } state_e;

  state_e             state_q, state_d;
  logic [ChW-1:0]     ch_q, ch_d;
  logic [CcW-1:0]     cc_q;
  logic [AccW-1:0]    tmp_q;

  logic [DataW-1:0]   r0_q      [NumCh];
  logic [IvlW-1:0]    ivl_q     [NumCh];
  logic [AccW-1:0]    off_acc_q [NumCh];
  logic [DataW-1:0]   vol_q     [NumVoices];
  logic [DataW-1:0]   flo_q     [NumVoices];
  logic [2:0]         fhi_q     [NumVoices];
  logic [TblW-1:0]    tbl_q     [NumVoices];
  logic [PosW-1:0]    pos_q     [NumVoices];
  logic [AccW-1:0]    per_acc_q [NumVoices];
  logic [AccW-1:0]    smp_acc_q;

  logic [SumW-1:0]    left_q, right_q;
  logic [SumW-1:0]    out_left_q, out_right_q;
  logic               out_valid_q;

  logic               in_acc, wr_acc, tick_acc;
  logic [OffW-1:0]    wr_off;
  logic [DataW-1:0]   wr_data;
  logic [ChW-1:0]     wr_ch;
  logic [2:0]         wr_rg;
  logic               wave_we, shut_we, creg_we;

  alu_op_e            alu_op;
  logic [AccW-1:0]    alu_a, alu_b;
  alu_out_t           alu_out;

  logic               off_on, voice_on, mix_on, out_load;
  logic [IvlW-1:0]    ivl_dec;
  logic [10:0]        freq;
  logic [11:0]        span;
  logic [PeriodW-1:0] period;
  logic [WaveAw-1:0]  raddr;
  logic [SmpW-1:0]    rdata;
  logic [SumW-1:0]    prod_l, prod_r;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign wr_acc   = in_acc & ~s_axis_tuser;
  assign tick_acc = in_acc & s_axis_tuser;
  assign wr_off   = s_axis_tdata[10:0];
  assign wr_data  = s_axis_tdata[18:11];
  assign wr_ch    = wr_off[8:6];
  assign wr_rg    = wr_off[4:2];

  assign wave_we = wr_acc & (wr_off < WAVE_END);
  assign shut_we = wr_acc & (wr_off == SHUTOFF_PORT) & wr_data[0];
  assign creg_we = wr_acc & (wr_off >= MOD_END) & (wr_off != SHUTOFF_PORT)
                 & (wr_ch <= LAST_CH) & ~wr_off[5];

  assign off_on   = r0_q[ch_q][7] & r0_q[ch_q][5];
  assign voice_on = r0_q[ch_q][7];
  assign ivl_dec  = ivl_q[ch_q] - 6'd1;
  assign freq     = {fhi_q[ch_q], flo_q[ch_q]};
  assign span     = FREQ_BASE - {1'b0, freq};
  assign period   = {span, 2'b00};
  assign mix_on   = voice_on & (tbl_q[ch_q] <= MAX_TBL);
  assign raddr    = mix_on ? {tbl_q[ch_q], pos_q[ch_q]} : '0;
  assign prod_l   = {7'd0, rdata} * {9'd0, vol_q[ch_q][7:4]};
  assign prod_r   = {7'd0, rdata} * {9'd0, vol_q[ch_q][3:0]};
  assign out_load = (state_q == ST_EMIT) & (~out_valid_q | m_axis_tready);

  always_comb begin
    alu_op = ALU_ADD_SAT;
    alu_a  = tmp_q;
    alu_b  = '0;
    case (state_q)
      ST_OFF_ADD: begin
        alu_a = off_acc_q[ch_q];
        alu_b = {24'd0, cc_q};
      end
      ST_OFF_SUB: begin
        alu_op = ALU_SUB_GE;
        alu_b  = OFF_TICK_CYCLES;
      end
      ST_V_ADD: begin
        alu_a = per_acc_q[ch_q];
        alu_b = {24'd0, cc_q};
      end
      ST_V_SUB: begin
        alu_op = ALU_SUB_GE;
        alu_b  = {18'd0, period};
      end
      ST_S_ADD: begin
        alu_a = smp_acc_q;
        alu_b = {24'd0, cc_q};
      end
      ST_S_SUB: begin
        alu_op = ALU_SUB_GE;
        alu_b  = MIX_PERIOD;
      end
      default: begin
        alu_op = ALU_ADD_SAT;
      end
    endcase
  end

  wsc_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .out_o (alu_out)
  );

  wsc_wave_ram u_wave_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (wave_we),
    .waddr_i (wr_off[9:2]),
    .wdata_i (wr_data[5:0]),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    unique case (state_q)
      ST_IDLE: begin
        if (tick_acc) begin
          ch_d    = '0;
          state_d = ST_OFF_ADD;
        end
      end
      ST_OFF_ADD: begin
        if (off_on) begin
          state_d = ST_OFF_SUB;
        end else begin
          state_d = (ch_q == LAST_CH) ? ST_S_ADD : ST_V_ADD;
        end
      end
      ST_OFF_SUB: begin
        state_d = (ch_q == LAST_CH) ? ST_S_ADD : ST_V_ADD;
      end
      ST_V_ADD: begin
        if (voice_on) begin
          state_d = ST_V_SUB;
        end else begin
          ch_d    = ch_q + 3'd1;
          state_d = ST_OFF_ADD;
        end
      end
      ST_V_SUB: begin
        ch_d    = ch_q + 3'd1;
        state_d = ST_OFF_ADD;
      end
      ST_S_ADD: begin
        state_d = ST_S_SUB;
      end
      ST_S_SUB: begin
        if (alu_out.ge) begin
          ch_d    = '0;
          state_d = ST_MIX_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MIX_RD: begin
        state_d = ST_MIX_ACC;
      end
      ST_MIX_ACC: begin
        if (ch_q == LAST_VOICE) begin
          state_d = ST_EMIT;
        end else begin
          ch_d    = ch_q + 3'd1;
          state_d = ST_MIX_RD;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumCh; k++) begin
        r0_q[k]      <= '0;
        ivl_q[k]     <= '0;
        off_acc_q[k] <= '0;
      end
      for (int k = 0; k < NumVoices; k++) begin
        vol_q[k]     <= '0;
        flo_q[k]     <= '0;
        fhi_q[k]     <= '0;
        tbl_q[k]     <= '0;
        pos_q[k]     <= '0;
        per_acc_q[k] <= '0;
      end
      smp_acc_q <= '0;
    end else begin
      if (shut_we) begin
        for (int k = 0; k < NumCh; k++) begin
          r0_q[k] <= '0;
        end
      end
      if (creg_we) begin
        unique case (wr_rg)
          REG_CTRL: begin
            r0_q[wr_ch]      <= wr_data;
            ivl_q[wr_ch]     <= {1'b0, wr_data[4:0]} + 6'd1;
            off_acc_q[wr_ch] <= '0;
            if (wr_ch <= LAST_VOICE) begin
              pos_q[wr_ch]     <= '0;
              per_acc_q[wr_ch] <= '0;
            end
          end
          REG_VOL: begin
            if (wr_ch <= LAST_VOICE) vol_q[wr_ch] <= wr_data;
          end
          REG_FLO: begin
            if (wr_ch <= LAST_VOICE) flo_q[wr_ch] <= wr_data;
          end
          REG_FHI: begin
            if (wr_ch <= LAST_VOICE) fhi_q[wr_ch] <= wr_data[2:0];
          end
          REG_TBL: begin
            if (wr_ch <= LAST_VOICE) tbl_q[wr_ch] <= wr_data[2:0];
          end
          default: begin
          end
        endcase
      end
      if (state_q == ST_OFF_SUB) begin
        off_acc_q[ch_q] <= alu_out.res;
        if (alu_out.ge) begin
          ivl_q[ch_q] <= ivl_dec;
          if (ivl_dec == '0) r0_q[ch_q] <= '0;
        end
      end
      if (state_q == ST_V_SUB) begin
        per_acc_q[ch_q] <= alu_out.res;
        if (alu_out.ge) pos_q[ch_q] <= pos_q[ch_q] + 5'd1;
      end
      if (state_q == ST_S_SUB) begin
        smp_acc_q <= alu_out.res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      cc_q <= s_axis_tdata[26:19];
    end
    if ((state_q == ST_OFF_ADD) || (state_q == ST_V_ADD) || (state_q == ST_S_ADD)) begin
      tmp_q <= alu_out.res;
    end
    if (state_q == ST_S_SUB) begin
      left_q  <= '0;
      right_q <= '0;
    end else if ((state_q == ST_MIX_ACC) && mix_on) begin
      left_q  <= left_q + prod_l;
      right_q <= right_q + prod_r;
    end
    if (out_load) begin
      out_left_q  <= left_q;
      out_right_q <= right_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_right_q, out_left_q};

endmodule
